// File: src/cme_pkg.sv
// ----------------------------------------------------------------------------
// cme_pkg: shared types, constants and helpers
// Sequencer states, register indexes, CORDIC widths, angle table and
// saturating arithmetic used across the central moments engine.
// ----------------------------------------------------------------------------
package cme_pkg;

	localparam int CW = 42;  // CORDIC x/y width, holds trig sums with gain
	localparam int ZW = 36;  // CORDIC angle width, turns in Q0.32

	localparam logic signed [ZW-1:0] HALF_TURN    = 36'sh0_8000_0000;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 36'sh0_4000_0000;

	localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [2:0] {
		REG_PERIODIC    = 3'd0,
		REG_DOMAIN_MIN  = 3'd1,
		REG_DOMAIN_MAX  = 3'd2,
		REG_SPAN_RECIP  = 3'd3,
		REG_POWER_COUNT = 3'd4,
		REG_POWER_LIST  = 3'd5,
		REG_WANT_DERIV  = 3'd6
	} cme_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PH_MUL,
		ST_ROT,
		ST_MEAN,
		ST_VEC,
		ST_MEAN_MUL,
		ST_AMEAN,
		ST_DEV,
		ST_DMUL1,
		ST_DMUL2,
		ST_POW_INIT,
		ST_TERM,
		ST_LCHK,
		ST_LMUL,
		ST_LDIV,
		ST_MMUL,
		ST_MDIV,
		ST_EMIT_PREP,
		ST_DSUB,
		ST_DDIV,
		ST_EMIT
	} cme_state_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			s = a[63] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a - b;
		if ((a[63] != b[63]) && (s[63] != a[63])) begin
			s = a[63] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	// atan(2^-i) in Q0.32 turns
	function automatic logic [31:0] cordic_angle(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/cme_mul.sv
// ----------------------------------------------------------------------------
// cme_mul: iterative signed 64x64 multiplier
// Four 32x32 partial products on magnitudes, one per cycle; gives the full
// signed product and the saturated Q32.32 product.
// ----------------------------------------------------------------------------
module cme_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	output logic                 done,
	output logic signed [127:0]  prod,
	output logic signed [63:0]   q32
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;
	logic signed [127:0] prod_q;
	logic signed [63:0]  q32_q;

	logic [31:0]  opa, opb;
	logic [63:0]  pp;
	logic [127:0] addend;
	logic [62:0]  mag;

	assign opa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign opb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign pp  = opa * opb;
	assign mag = acc_q[94:32];

	always_comb begin
		case (cnt_q)
			2'd0:    addend = {64'd0, pp};
			2'd3:    addend = {pp, 64'd0};
			default: addend = {32'd0, pp, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[63] ? 64'(-a) : 64'(a);
			ub_q  <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= 128'd0;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
		end
		if (fin_q) begin
			prod_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
			if (acc_q[127:95] != 33'd0) begin
				q32_q <= neg_q ? cme_pkg::Q_MIN : cme_pkg::Q_MAX;
			end else begin
				q32_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;
	assign q32  = q32_q;

endmodule

// File: src/cme_div.sv
// ----------------------------------------------------------------------------
// cme_div: iterative signed divide by a small count
// Restoring division on the magnitude, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cme_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic [4:0]         divisor,
	output logic               done,
	output logic signed [63:0] quotient
);

	logic [63:0] mag_q;
	logic [4:0]  rem_q, div_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q, fin_q, done_q;
	logic signed [63:0] quot_q;

	logic [5:0] trial, diff;
	logic       ge;

	assign trial = {rem_q, mag_q[63]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
			neg_q <= dividend[63];
			div_q <= divisor;
			rem_q <= 5'd0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[4:0] : trial[4:0];
			mag_q <= {mag_q[62:0], ge};
		end
		if (fin_q) begin
			quot_q <= neg_q ? -$signed(mag_q) : $signed(mag_q);
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// File: src/cme_cordic.sv
// ----------------------------------------------------------------------------
// cme_cordic: shared CORDIC, rotation and vectoring
// One micro-rotation per cycle. Rotation gives unscaled cosine and sine of a
// phase in turns; vectoring gives atan2 in turns.
// ----------------------------------------------------------------------------
module cme_cordic #(
	parameter int STEPS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           vector_mode,
	input  logic [31:0]                    phase,
	input  logic signed [cme_pkg::CW-1:0]  x_in,
	input  logic signed [cme_pkg::CW-1:0]  y_in,
	output logic                           done,
	output logic signed [cme_pkg::CW-1:0]  cos_out,
	output logic signed [cme_pkg::CW-1:0]  sin_out,
	output logic signed [cme_pkg::ZW-1:0]  angle_out
);

	localparam int IW = $clog2(STEPS + 1);

	logic signed [cme_pkg::CW-1:0] x_q, y_q, xs, ys;
	logic signed [cme_pkg::ZW-1:0] z_q, ang, z0;
	logic [IW-1:0] i_q;
	logic vec_q, flip_q, zero_q, busy_q, fin_q, done_q, up;
	logic signed [cme_pkg::CW-1:0] cos_q, sin_q;
	logic signed [cme_pkg::ZW-1:0] angle_q;

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign ang = $signed({4'd0, cme_pkg::cordic_angle(5'(i_q))});
	assign up  = vec_q ? (y_q <= 0) : (z_q >= 0);
	// phase as signed turns in [-1/2, 1/2)
	assign z0  = $signed({{4{phase[31]}}, phase});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= vector_mode;
			if (vector_mode) begin
				flip_q <= 1'b0;
				zero_q <= (x_in == 0) && (y_in == 0);
				if (x_in < 0) begin
					z_q <= (y_in >= 0) ? cme_pkg::HALF_TURN : -cme_pkg::HALF_TURN;
					x_q <= -x_in;
					y_q <= -y_in;
				end else begin
					z_q <= '0;
					x_q <= x_in;
					y_q <= y_in;
				end
			end else begin
				zero_q <= 1'b0;
				x_q    <= cme_pkg::CW'(64'sd1073741824);
				y_q    <= '0;
				// fold into the right half plane
				if (z0 > cme_pkg::QUARTER_TURN) begin
					z_q    <= z0 - cme_pkg::HALF_TURN;
					flip_q <= 1'b1;
				end else if (z0 < -cme_pkg::QUARTER_TURN) begin
					z_q    <= z0 + cme_pkg::HALF_TURN;
					flip_q <= 1'b1;
				end else begin
					z_q    <= z0;
					flip_q <= 1'b0;
				end
			end
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
		if (fin_q) begin
			cos_q   <= flip_q ? -x_q : x_q;
			sin_q   <= flip_q ? -y_q : y_q;
			angle_q <= zero_q ? '0 : z_q;
		end
	end

	assign done      = done_q;
	assign cos_out   = cos_q;
	assign sin_out   = sin_q;
	assign angle_out = angle_q;

endmodule

// File: src/central_moments_engine_top.sv
// ----------------------------------------------------------------------------
// central_moments_engine_top: central moments of a sample set
// Loads signed Q16.16 samples, forms the arithmetic or circular mean and
// emits saturated Q32.32 central moments and optional per-sample derivatives.
// ----------------------------------------------------------------------------
// Usage
//  - Input stream s_*: one sample per item, tlast closes the set. Each stored
//    sample is run through the shared multiplier and the CORDIC rotation to
//    update the trig sums; s_tready is low meanwhile.
//    A sample arriving with the store full is dropped, its tlast still counts.
//  - After tlast the single sequencer works through the mean, deviations,
//    powers and divisions. The divider sets the pace: each sample and power
//    costs two divides plus (p-1) multiplies, and a derivative one more divide.
//  - Output stream m_*: one item per moment (or per moment and sample when
//    derivatives are on), tlast on the final item of the set. A registered
//    output stage holds the item; a stalled receiver simply holds the
//    sequencer, nothing is lost.
//  - Config channel cfg_*: always ready; write only while idle.
//  - Reset clears the set, the sums and restores register defaults (one
//    power of order 2, derivatives on). The sample store is not cleared.
// ----------------------------------------------------------------------------
module central_moments_engine_top #(
	parameter int MAX_SAMPLES  = 16,
	parameter int MAX_POWERS   = 4,
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	// sample stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] sample_value
	input  logic         s_tlast,   // last_sample
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // [1:0] moment_index, [5:2] sample_index,
	                                // [69:6] moment_value, [133:70] derivative_value
	output logic         m_tlast,   // last_result
	// register writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int IDXW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int TW   = cme_pkg::ZW + 1;
	localparam logic signed [TW-1:0] T_HALF = TW'(64'sh8000_0000);
	localparam logic signed [TW-1:0] T_FULL = TW'(64'sh1_0000_0000);
	localparam logic signed [68:0] DP_MAX = 69'(cme_pkg::Q_MAX);
	localparam logic signed [68:0] DP_MIN = 69'(cme_pkg::Q_MIN);

	// configuration
	logic        periodic_q, want_q;
	logic [31:0] dmin_q, dmax_q, srec_q;
	logic [2:0]  pcount_q;
	logic [15:0] plist_q;

	// set state
	logic signed [31:0] store_q [MAX_SAMPLES];
	logic signed [63:0] dev_q   [MAX_SAMPLES];
	logic signed [63:0] low_q   [MAX_SAMPLES];
	logic [CNTW-1:0]    count_q;
	logic signed [39:0] sum_q, sin_q, cos_q;
	logic signed [31:0] mean_q;
	logic signed [63:0] lowsum_q, momsum_q, l_q, scr_q, der_q;
	logic [IDXW-1:0]    i_q;
	logic [1:0]         k_q;
	logic [3:0]         j_q, p_q;
	logic               last_q, go_q;

	cme_pkg::cme_state_t state_q, state_d;
	logic go_d;

	// output stage
	logic               m_tvalid_q, out_last_q;
	logic [1:0]         out_k_q;
	logic [3:0]         out_i_q;
	logic signed [63:0] out_mom_q, out_der_q;

	// shared units
	logic               mul_start, mul_done, div_start, div_done, cor_start, cor_done;
	logic signed [63:0] mul_a, mul_b, mul_q32, div_in, div_out;
	logic signed [127:0] mul_prod;
	logic signed [cme_pkg::CW-1:0] cor_cos, cor_sin;
	logic signed [cme_pkg::ZW-1:0] cor_angle;

	logic               full, last_i, last_k, out_free, accept;
	logic [2:0]         pc_eff;
	logic [3:0]         p_raw;
	logic signed [63:0] span64, dev_i;
	logic signed [32:0] d_w;
	logic signed [TW-1:0] t_w;
	logic signed [68:0] dp_w;

	assign span64   = $signed({{32{dmax_q[31]}}, dmax_q}) - $signed({{32{dmin_q[31]}}, dmin_q});
	assign full     = count_q >= CNTW'(MAX_SAMPLES);
	assign last_i   = CNTW'(i_q) == (count_q - CNTW'(1));
	assign dev_i    = dev_q[i_q];
	assign d_w      = $signed({store_q[i_q][31], store_q[i_q]}) - $signed({mean_q[31], mean_q});
	assign t_w      = T_HALF + TW'(cor_angle);
	assign dp_w     = div_out * $signed({1'b0, p_q});
	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign p_raw    = plist_q[4 * k_q +: 4];

	always_comb begin
		if (pcount_q == 3'd0) begin
			pc_eff = 3'd1;
		end else if (pcount_q > 3'(MAX_POWERS)) begin
			pc_eff = 3'(MAX_POWERS);
		end else begin
			pc_eff = pcount_q;
		end
	end
	assign last_k = {1'b0, k_q} == (pc_eff - 3'd1);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cme_pkg::ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
		end
	end

	always_comb begin
		state_d = state_q;
		go_d    = 1'b0;
		case (state_q)
			cme_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (!full) begin
						state_d = cme_pkg::ST_PH_MUL;
						go_d    = 1'b1;
					end else if (s_tlast) begin
						state_d = cme_pkg::ST_MEAN;
					end
				end
			end
			cme_pkg::ST_PH_MUL: begin
				if (mul_done) begin
					state_d = cme_pkg::ST_ROT;
					go_d    = 1'b1;
				end
			end
			cme_pkg::ST_ROT: begin
				if (cor_done) begin
					state_d = last_q ? cme_pkg::ST_MEAN : cme_pkg::ST_IDLE;
				end
			end
			cme_pkg::ST_MEAN: begin
				go_d    = 1'b1;
				state_d = periodic_q ? cme_pkg::ST_VEC : cme_pkg::ST_AMEAN;
			end
			cme_pkg::ST_VEC: begin
				if (cor_done) begin
					state_d = cme_pkg::ST_MEAN_MUL;
					go_d    = 1'b1;
				end
			end
			cme_pkg::ST_MEAN_MUL: begin
				if (mul_done) state_d = cme_pkg::ST_DEV;
			end
			cme_pkg::ST_AMEAN: begin
				if (div_done) state_d = cme_pkg::ST_DEV;
			end
			cme_pkg::ST_DEV: begin
				if (periodic_q) begin
					state_d = cme_pkg::ST_DMUL1;
					go_d    = 1'b1;
				end else begin
					state_d = last_i ? cme_pkg::ST_POW_INIT : cme_pkg::ST_DEV;
				end
			end
			cme_pkg::ST_DMUL1: begin
				if (mul_done) begin
					state_d = cme_pkg::ST_DMUL2;
					go_d    = 1'b1;
				end
			end
			cme_pkg::ST_DMUL2: begin
				if (mul_done) state_d = last_i ? cme_pkg::ST_POW_INIT : cme_pkg::ST_DEV;
			end
			cme_pkg::ST_POW_INIT: state_d = cme_pkg::ST_TERM;
			cme_pkg::ST_TERM:     state_d = cme_pkg::ST_LCHK;
			cme_pkg::ST_LCHK: begin
				go_d    = 1'b1;
				state_d = (j_q < p_q) ? cme_pkg::ST_LMUL : cme_pkg::ST_LDIV;
			end
			cme_pkg::ST_LMUL: begin
				if (mul_done) state_d = cme_pkg::ST_LCHK;
			end
			cme_pkg::ST_LDIV: begin
				if (div_done) begin
					state_d = cme_pkg::ST_MMUL;
					go_d    = 1'b1;
				end
			end
			cme_pkg::ST_MMUL: begin
				if (mul_done) begin
					state_d = cme_pkg::ST_MDIV;
					go_d    = 1'b1;
				end
			end
			cme_pkg::ST_MDIV: begin
				if (div_done) state_d = last_i ? cme_pkg::ST_EMIT_PREP : cme_pkg::ST_TERM;
			end
			cme_pkg::ST_EMIT_PREP: begin
				state_d = want_q ? cme_pkg::ST_DSUB : cme_pkg::ST_EMIT;
			end
			cme_pkg::ST_DSUB: begin
				state_d = cme_pkg::ST_DDIV;
				go_d    = 1'b1;
			end
			cme_pkg::ST_DDIV: begin
				if (div_done) state_d = cme_pkg::ST_EMIT;
			end
			cme_pkg::ST_EMIT: begin
				if (out_free) begin
					if (want_q && !last_i) begin
						state_d = cme_pkg::ST_DSUB;
					end else if (last_k) begin
						state_d = cme_pkg::ST_IDLE;
					end else begin
						state_d = cme_pkg::ST_POW_INIT;
					end
				end
			end
			default: state_d = cme_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = state_q == cme_pkg::ST_IDLE;

	// ---------------- shared unit hookup ----------------
	always_comb begin
		mul_start = go_q && (state_q inside {cme_pkg::ST_PH_MUL, cme_pkg::ST_MEAN_MUL,
			cme_pkg::ST_DMUL1, cme_pkg::ST_DMUL2, cme_pkg::ST_LMUL, cme_pkg::ST_MMUL});
		div_start = go_q && (state_q inside {cme_pkg::ST_AMEAN, cme_pkg::ST_LDIV,
			cme_pkg::ST_MDIV, cme_pkg::ST_DDIV});
		cor_start = go_q && (state_q inside {cme_pkg::ST_ROT, cme_pkg::ST_VEC});

		case (state_q)
			cme_pkg::ST_MEAN_MUL, cme_pkg::ST_DMUL2: mul_a = span64;
			cme_pkg::ST_LMUL, cme_pkg::ST_MMUL:      mul_a = l_q;
			default:                                 mul_a = scr_q;
		endcase
		case (state_q)
			cme_pkg::ST_PH_MUL, cme_pkg::ST_DMUL1:   mul_b = $signed({32'd0, srec_q});
			cme_pkg::ST_MEAN_MUL, cme_pkg::ST_DMUL2: mul_b = scr_q;
			default:                                 mul_b = dev_i;
		endcase
		case (state_q)
			cme_pkg::ST_AMEAN: div_in = 64'(sum_q);
			cme_pkg::ST_LDIV:  div_in = l_q;
			default:           div_in = scr_q;
		endcase
	end

	cme_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod),
		.q32    (mul_q32)
	);

	cme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (5'(count_q)),
		.done     (div_done),
		.quotient (div_out)
	);

	cme_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cor_start),
		.vector_mode (state_q == cme_pkg::ST_VEC),
		.phase       (mul_prod[47:16]),
		.x_in        (cme_pkg::CW'(cos_q)),
		.y_in        (cme_pkg::CW'(sin_q)),
		.done        (cor_done),
		.cos_out     (cor_cos),
		.sin_out     (cor_sin),
		.angle_out   (cor_angle)
	);

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_q <= 1'b0;
			dmin_q     <= 32'd0;
			dmax_q     <= 32'd0;
			srec_q     <= 32'd0;
			pcount_q   <= 3'd1;
			plist_q    <= 16'd2;
			want_q     <= 1'b1;
		end else if (cfg_valid) begin
			case (cme_pkg::cme_reg_t'(cfg_index))
				cme_pkg::REG_PERIODIC:    periodic_q <= cfg_data[0];
				cme_pkg::REG_DOMAIN_MIN:  dmin_q     <= cfg_data;
				cme_pkg::REG_DOMAIN_MAX:  dmax_q     <= cfg_data;
				cme_pkg::REG_SPAN_RECIP:  srec_q     <= cfg_data;
				cme_pkg::REG_POWER_COUNT: pcount_q   <= cfg_data[2:0];
				cme_pkg::REG_POWER_LIST:  plist_q    <= cfg_data[15:0];
				cme_pkg::REG_WANT_DERIV:  want_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			sin_q      <= '0;
			cos_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) m_tvalid_q <= 1'b0;
			if (accept && !full) begin
				count_q <= count_q + CNTW'(1);
				sum_q   <= sum_q + 40'(signed'(s_tdata));
			end
			if (state_q == cme_pkg::ST_ROT && cor_done) begin
				cos_q <= cos_q + cor_cos[39:0];
				sin_q <= sin_q + cor_sin[39:0];
			end
			if (state_q == cme_pkg::ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
				if (last_k && !(want_q && !last_i)) begin
					// set done: back to an empty store
					count_q <= '0;
					sum_q   <= '0;
					sin_q   <= '0;
					cos_q   <= '0;
				end
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			cme_pkg::ST_IDLE: begin
				if (accept && !full) begin
					store_q[count_q[IDXW-1:0]] <= s_tdata;
					last_q <= s_tlast;
					scr_q  <= $signed({{32{s_tdata[31]}}, s_tdata})
						- $signed({{32{dmin_q[31]}}, dmin_q});
				end
			end
			cme_pkg::ST_MEAN: i_q <= '0;
			cme_pkg::ST_VEC: begin
				if (cor_done) begin
					if (t_w < 0) begin
						scr_q <= '0;
					end else if (t_w > T_FULL) begin
						scr_q <= 64'(T_FULL);
					end else begin
						scr_q <= 64'(t_w);
					end
				end
			end
			cme_pkg::ST_MEAN_MUL: begin
				if (mul_done) mean_q <= $signed(dmin_q + mul_prod[63:32]);
			end
			cme_pkg::ST_AMEAN: begin
				if (div_done) mean_q <= div_out[31:0];
			end
			cme_pkg::ST_DEV: begin
				if (periodic_q) begin
					scr_q <= 64'(d_w);
				end else begin
					dev_q[i_q] <= $signed({{15{d_w[32]}}, d_w, 16'd0});
					i_q <= last_i ? '0 : i_q + 1'b1;
				end
			end
			cme_pkg::ST_DMUL1: begin
				if (mul_done) scr_q <= $signed({{32{mul_prod[47]}}, mul_prod[47:16]});
			end
			cme_pkg::ST_DMUL2: begin
				if (mul_done) begin
					dev_q[i_q] <= $signed({mul_prod[79:32], 16'd0});
					i_q <= last_i ? '0 : i_q + 1'b1;
				end
			end
			cme_pkg::ST_POW_INIT: begin
				p_q      <= (p_raw < 4'd2) ? 4'd2 : p_raw;
				lowsum_q <= '0;
				momsum_q <= '0;
				i_q      <= '0;
			end
			cme_pkg::ST_TERM: begin
				l_q <= dev_i;
				j_q <= 4'd2;
			end
			cme_pkg::ST_LCHK: begin
				if (!(j_q < p_q)) low_q[i_q] <= l_q;
			end
			cme_pkg::ST_LMUL: begin
				if (mul_done) begin
					l_q <= mul_q32;
					j_q <= j_q + 4'd1;
				end
			end
			cme_pkg::ST_LDIV: begin
				if (div_done) lowsum_q <= cme_pkg::sat_add(lowsum_q, div_out);
			end
			cme_pkg::ST_MMUL: begin
				if (mul_done) scr_q <= mul_q32;
			end
			cme_pkg::ST_MDIV: begin
				if (div_done) begin
					momsum_q <= cme_pkg::sat_add(momsum_q, div_out);
					i_q <= last_i ? '0 : i_q + 1'b1;
				end
			end
			cme_pkg::ST_EMIT_PREP: der_q <= '0;
			cme_pkg::ST_DSUB: scr_q <= cme_pkg::sat_sub(low_q[i_q], lowsum_q);
			cme_pkg::ST_DDIV: begin
				if (div_done) begin
					if (dp_w > DP_MAX) begin
						der_q <= cme_pkg::Q_MAX;
					end else if (dp_w < DP_MIN) begin
						der_q <= cme_pkg::Q_MIN;
					end else begin
						der_q <= dp_w[63:0];
					end
				end
			end
			cme_pkg::ST_EMIT: begin
				if (out_free) begin
					out_k_q    <= k_q;
					out_i_q    <= want_q ? 4'(i_q) : 4'd0;
					out_mom_q  <= momsum_q;
					out_der_q  <= der_q;
					out_last_q <= last_k && (!want_q || last_i);
					if (want_q && !last_i) begin
						i_q <= i_q + 1'b1;
					end else if (last_k) begin
						k_q <= 2'd0;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
			end
			default: ;
		endcase
		if (state_q == cme_pkg::ST_IDLE && accept) k_q <= 2'd0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'd0, out_der_q, out_mom_q, out_i_q, out_k_q};

endmodule
